// ===== sv/kcrb_pkg.sv =====
// ----------------------------------------------------------------------------
// kcrb_pkg
// Shared types and constants for the mirrored-border convolution core.
// ----------------------------------------------------------------------------
package kcrb_pkg;

    localparam int PIX_W     = 16;
    localparam int COEF_W    = 16;
    localparam int OUT_W     = 32;
    localparam int COORD_W   = 8;
    localparam int CIDX_W    = 6;
    localparam int FRAC_BITS = 12;
    localparam int ACC_W     = 48;
    localparam int CFG_DW    = 32;
    localparam int CFG_AW    = 4;
    localparam int SIZE_W    = 9;
    localparam int RAD_W     = 2;

    localparam logic [1:0] CMD_WRITE_PIXEL = 2'd0;
    localparam logic [1:0] CMD_WRITE_COEF  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE     = 2'd2;

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_KERNEL_RADIUS = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FLUSH,
        S_FINISH
    } seq_state_t;

    typedef struct packed {
        logic clear;
        logic tap_vld;
    } mac_ctrl_t;

endpackage

// ===== sv/kcrb_ram.sv =====
// ----------------------------------------------------------------------------
// kcrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kcrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/kcrb_mirror.sv =====
// ----------------------------------------------------------------------------
// kcrb_mirror
// Reflects one tap coordinate into the image and clamps it into range.
// ----------------------------------------------------------------------------
module kcrb_mirror import kcrb_pkg::*; #(
    parameter int KW = 3,
    parameter int SW = 9,
    parameter int DW = 8
) (
    input  logic [COORD_W-1:0]   center,
    input  logic signed [KW-1:0] offset,
    input  logic [SW-1:0]        size,
    output logic [DW-1:0]        idx
);

    localparam int MW = SW + 2;
    localparam logic signed [MW-1:0] ZERO = MW'(0);
    localparam logic signed [MW-1:0] ONE  = MW'(1);

    logic signed [MW-1:0] pos;
    logic signed [MW-1:0] s;
    logic signed [MW-1:0] a;
    logic signed [MW-1:0] b;
    logic signed [MW-1:0] c;

    always_comb
    begin
        pos = $signed(MW'(center)) + MW'(offset);
        s   = $signed(MW'(size));
        a   = (pos < ZERO) ? -pos : pos;
        b   = (a >= s) ? (s + s - ONE - a) : a;
        if (b < ZERO)
        begin
            c = ZERO;
        end
        else if (b > s - ONE)
        begin
            c = s - ONE;
        end
        else
        begin
            c = b;
        end
        idx = c[DW-1:0];
    end

endmodule

// ===== sv/kcrb_mac.sv =====
// ----------------------------------------------------------------------------
// kcrb_mac
// Shared multiply-accumulate unit with floor shift and 32-bit saturation.
// ----------------------------------------------------------------------------
module kcrb_mac import kcrb_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctrl_t                ctrl,
    input  logic signed [PIX_W-1:0]  pixel,
    input  logic signed [COEF_W-1:0] coef,
    output logic signed [OUT_W-1:0]  result
);

    localparam int SH_W = ACC_W - FRAC_BITS;

    logic                            rd_vld_reg;
    logic                            prod_vld_reg;
    logic signed [PIX_W+COEF_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]         acc_reg;
    logic signed [ACC_W-1:0]         acc_next;
    logic signed [SH_W-1:0]          shifted;
    logic [SH_W-OUT_W:0]             hi_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= ctrl.tap_vld;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= pixel * coef;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // arithmetic shift by dropping fraction bits rounds toward minus infinity
    always_comb
    begin
        shifted = acc_reg[ACC_W-1:FRAC_BITS];
        hi_bits = shifted[SH_W-1:OUT_W-1];
        if ((&hi_bits) || !(|hi_bits))
        begin
            result = shifted[OUT_W-1:0];
        end
        else if (shifted[SH_W-1])
        begin
            result = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

endmodule

// ===== sv/kernel_convolution_reflect_border_core.sv =====
// ----------------------------------------------------------------------------
// kernel_convolution_reflect_border_core
// Square-kernel 2-D convolution over a stored image with mirrored borders.
// ----------------------------------------------------------------------------
// Write items leave busy low, so the next start is taken. Compute items keep
// busy high through S_RUN, S_DRAIN, S_FLUSH and S_FINISH; S_RUN feeds one tap
// per cycle through the shared multiply-accumulate, S_DRAIN and S_FLUSH cover the
// memory and product registers, and out_strobe is registered from S_FINISH.
// rst_n clears control state and the registers (256, 256, 1); the pixel and
// coefficient memories are undefined until written. Results cannot be stalled.
module kernel_convolution_reflect_border_core import kcrb_pkg::*; #(
    parameter int MAX_DIM    = 256,
    parameter int MAX_RADIUS = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                command,
    input  logic [COORD_W-1:0]        column,
    input  logic [COORD_W-1:0]        row_index,
    input  logic signed [PIX_W-1:0]   pixel_value,
    input  logic [CIDX_W-1:0]         coef_index,
    input  logic signed [COEF_W-1:0]  coef_value,
    output logic                      out_strobe,
    output logic signed [OUT_W-1:0]   out_value,
    output logic [COORD_W-1:0]        out_column,
    output logic [COORD_W-1:0]        out_row,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_AW-1:0]         paddr,
    input  logic [CFG_DW-1:0]         pwdata,
    output logic [CFG_DW-1:0]         prdata,
    output logic                      pready
);

    localparam int DW    = $clog2(MAX_DIM);
    localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
    localparam int SW    = (DW + 1 > SIZE_W) ? DW + 1 : SIZE_W;
    localparam int KSIDE = 2 * MAX_RADIUS + 1;
    localparam int KTAPS = KSIDE * KSIDE;
    localparam int KAW   = $clog2(KTAPS);
    localparam int KW    = $clog2(MAX_RADIUS + 1) + 1;

    seq_state_t              state_reg;
    seq_state_t              state_next;
    logic signed [KW-1:0]    kx_reg;
    logic signed [KW-1:0]    kx_next;
    logic signed [KW-1:0]    ky_reg;
    logic signed [KW-1:0]    ky_next;
    logic signed [KW-1:0]    r_reg;
    logic signed [KW-1:0]    r_next;
    logic [KAW-1:0]          n_reg;
    logic [KAW-1:0]          n_next;
    logic [COORD_W-1:0]      col_reg;
    logic [COORD_W-1:0]      row_reg;

    logic [SIZE_W-1:0]       image_width_reg;
    logic [SIZE_W-1:0]       image_height_reg;
    logic [RAD_W-1:0]        kernel_radius_reg;

    logic                    out_strobe_reg;
    logic signed [OUT_W-1:0] out_value_reg;
    logic [COORD_W-1:0]      out_column_reg;
    logic [COORD_W-1:0]      out_row_reg;

    logic                    accept;
    logic                    cfg_wr;
    logic [SW-1:0]           w_size;
    logic [SW-1:0]           h_size;
    logic signed [KW-1:0]    r_eff;
    logic [DW-1:0]           sx;
    logic [DW-1:0]           sy;
    logic                    pix_we;
    logic [AW-1:0]           pix_wr_addr;
    logic [AW-1:0]           pix_rd_addr;
    logic [PIX_W-1:0]        pix_rd_data;
    logic                    coef_we;
    logic [COEF_W-1:0]       coef_rd_data;
    mac_ctrl_t               mac_ctrl;
    logic signed [OUT_W-1:0] mac_result;

    assign accept = start && (state_reg == S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // effective sizes and radius
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w_size = SW'(1);
        end
        else if (int'(image_width_reg) > MAX_DIM)
        begin
            w_size = SW'(MAX_DIM);
        end
        else
        begin
            w_size = SW'(image_width_reg);
        end

        if (image_height_reg == '0)
        begin
            h_size = SW'(1);
        end
        else if (int'(image_height_reg) > MAX_DIM)
        begin
            h_size = SW'(MAX_DIM);
        end
        else
        begin
            h_size = SW'(image_height_reg);
        end

        if (int'(kernel_radius_reg) > MAX_RADIUS)
        begin
            r_eff = KW'(MAX_RADIUS);
        end
        else
        begin
            r_eff = KW'(kernel_radius_reg);
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= SIZE_W'(256);
            image_height_reg  <= SIZE_W'(256);
            kernel_radius_reg <= RAD_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:   image_width_reg   <= pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= pwdata[SIZE_W-1:0];
                REG_KERNEL_RADIUS: kernel_radius_reg <= pwdata[RAD_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:   prdata = CFG_DW'(image_width_reg);
            REG_IMAGE_HEIGHT:  prdata = CFG_DW'(image_height_reg);
            REG_KERNEL_RADIUS: prdata = CFG_DW'(kernel_radius_reg);
            default:           prdata = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kx_reg    <= '0;
            ky_reg    <= '0;
            r_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kx_reg    <= kx_next;
            ky_reg    <= ky_next;
            r_reg     <= r_next;
            n_reg     <= n_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        kx_next          = kx_reg;
        ky_next          = ky_reg;
        r_next           = r_reg;
        n_next           = n_reg;
        mac_ctrl.clear   = 1'b0;
        mac_ctrl.tap_vld = 1'b0;
        busy             = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && command == CMD_COMPUTE)
                begin
                    state_next     = S_RUN;
                    kx_next        = -r_eff;
                    ky_next        = -r_eff;
                    r_next         = r_eff;
                    n_next         = '0;
                    mac_ctrl.clear = 1'b1;
                end
            end
            S_RUN:
            begin
                mac_ctrl.tap_vld = 1'b1;
                n_next           = n_reg + KAW'(1);
                if (kx_reg == r_reg)
                begin
                    kx_next = -r_reg;
                    if (ky_reg == r_reg)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        ky_next = ky_reg + KW'(1);
                    end
                end
                else
                begin
                    kx_next = kx_reg + KW'(1);
                end
            end
            S_DRAIN:  state_next = S_FLUSH;
            S_FLUSH:  state_next = S_FINISH;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg <= column;
            row_reg <= row_index;
        end
    end

    // tap addressing
    kcrb_mirror #(
        .KW (KW),
        .SW (SW),
        .DW (DW)
    ) u_mirror_x (
        .center (col_reg),
        .offset (kx_reg),
        .size   (w_size),
        .idx    (sx)
    );

    kcrb_mirror #(
        .KW (KW),
        .SW (SW),
        .DW (DW)
    ) u_mirror_y (
        .center (row_reg),
        .offset (ky_reg),
        .size   (h_size),
        .idx    (sy)
    );

    assign pix_rd_addr = AW'(int'(sy) * MAX_DIM + int'(sx));
    assign pix_wr_addr = AW'(int'(row_index) * MAX_DIM + int'(column));
    assign pix_we      = accept && (command == CMD_WRITE_PIXEL)
                         && (int'(column) < MAX_DIM) && (int'(row_index) < MAX_DIM);
    assign coef_we     = accept && (command == CMD_WRITE_COEF)
                         && (int'(coef_index) < KTAPS);

    kcrb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_pixel_ram (
        .clk     (clk),
        .wr_en   (pix_we),
        .wr_addr (pix_wr_addr),
        .wr_data (pixel_value),
        .rd_addr (pix_rd_addr),
        .rd_data (pix_rd_data)
    );

    kcrb_ram #(
        .WIDTH (COEF_W),
        .DEPTH (KTAPS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_we),
        .wr_addr (KAW'(coef_index)),
        .wr_data (coef_value),
        .rd_addr (n_reg),
        .rd_data (coef_rd_data)
    );

    kcrb_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .pixel  ($signed(pix_rd_data)),
        .coef   ($signed(coef_rd_data)),
        .result (mac_result)
    );

    // result transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_strobe_reg <= 1'b0;
        end
        else
        begin
            out_strobe_reg <= (state_reg == S_FINISH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH)
        begin
            out_value_reg  <= mac_result;
            out_column_reg <= col_reg;
            out_row_reg    <= row_reg;
        end
    end

    assign out_strobe = out_strobe_reg;
    assign out_value  = out_value_reg;
    assign out_column = out_column_reg;
    assign out_row    = out_row_reg;

endmodule

// ===== sim/tb_kernel_convolution_reflect_border_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kernel_convolution_reflect_border_core
// Self-checking bench for the mirrored-border convolution core. A queue-fed
// driver issues pixel, coefficient, compute and reserved commands in random
// bursts; an in-bench model of the image, kernel and border rule predicts
// every result, and a monitor checks each result strobe against it. The
// image size and kernel radius are reprogrammed over the APB port between
// phases, including degenerate and out-of-range sizes.
// ----------------------------------------------------------------------------
module tb_kernel_convolution_reflect_border_core;
    import kcrb_pkg::*;

    localparam int IMG_DIM        = 256;
    localparam int KMAX_RADIUS    = 3;
    localparam int KTAPS          = (2 * KMAX_RADIUS + 1) * (2 * KMAX_RADIUS + 1);
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 11;
    localparam int ITEMS_PER_PHASE = 44;
    localparam int COORD_SPAN     = 4;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic signed [PIX_W-1:0]  pix;
        logic [CIDX_W-1:0]        cidx;
        logic signed [COEF_W-1:0] cval;
    } cmd_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic [COORD_W-1:0]      col;
        logic [COORD_W-1:0]      row;
    } conv_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      start       = 1'b0;
    logic [1:0]                command     = CMD_WRITE_PIXEL;
    logic [COORD_W-1:0]        column      = '0;
    logic [COORD_W-1:0]        row_index   = '0;
    logic signed [PIX_W-1:0]   pixel_value = '0;
    logic [CIDX_W-1:0]         coef_index  = '0;
    logic signed [COEF_W-1:0]  coef_value  = '0;
    logic                      psel        = 1'b0;
    logic                      penable     = 1'b0;
    logic                      pwrite      = 1'b0;
    logic [CFG_AW-1:0]         paddr       = '0;
    logic [CFG_DW-1:0]         pwdata      = '0;

    logic                      busy;
    logic                      out_strobe;
    logic signed [OUT_W-1:0]   out_value;
    logic [COORD_W-1:0]        out_column;
    logic [COORD_W-1:0]        out_row;
    logic [CFG_DW-1:0]         prdata;
    logic                      pready;

    // image/kernel model and its copy of the registers
    logic signed [PIX_W-1:0]  image_mem    [0:IMG_DIM*IMG_DIM-1];
    logic signed [COEF_W-1:0] kernel_coefs [0:KTAPS-1];
    logic [SIZE_W-1:0]        cfg_width  = 9'd256;
    logic [SIZE_W-1:0]        cfg_height = 9'd256;
    logic [RAD_W-1:0]         cfg_radius = 2'd1;

    // stimulus bookkeeping: never read an entry before it is written
    bit pix_written  [0:IMG_DIM*IMG_DIM-1];
    bit coef_written [0:KTAPS-1];

    cmd_item_t    pending_cmds[$];
    conv_result_t expected_pixels[$];
    cmd_item_t    held_cmd;
    int           burst_left     = 0;
    int           gap_left       = 0;
    int           mismatch_count = 0;
    int           stall_cycles   = 0;

    kernel_convolution_reflect_border_core #(
        .MAX_DIM    (IMG_DIM),
        .MAX_RADIUS (KMAX_RADIUS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .column      (column),
        .row_index   (row_index),
        .pixel_value (pixel_value),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .out_strobe  (out_strobe),
        .out_value   (out_value),
        .out_column  (out_column),
        .out_row     (out_row),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int eff_size(input logic [SIZE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > IMG_DIM)
            return IMG_DIM;
        return int'(s);
    endfunction

    function automatic int mirror_tap(input int i, input int s);
        int m;
        m = (i < 0) ? -i : i;
        if (m >= s)
            m = 2 * s - 1 - m;
        if (m < 0)
            m = 0;
        if (m > s - 1)
            m = s - 1;
        return m;
    endfunction

    function automatic logic signed [OUT_W-1:0] convolve_at(input int col, input int row);
        int     w;
        int     h;
        int     r;
        int     n;
        int     ky;
        int     kx;
        int     sx;
        int     sy;
        longint acc;
        longint scaled;
        w   = eff_size(cfg_width);
        h   = eff_size(cfg_height);
        r   = int'(cfg_radius);
        n   = 0;
        acc = 0;
        for (ky = -r; ky <= r; ky++)
        begin
            sy = mirror_tap(row + ky, h);
            for (kx = -r; kx <= r; kx++)
            begin
                sx = mirror_tap(col + kx, w);
                acc += longint'(image_mem[sy * IMG_DIM + sx]) * longint'(kernel_coefs[n]);
                n++;
            end
        end
        scaled = acc >>> FRAC_BITS;
        if (scaled > longint'(32'sh7FFF_FFFF))
            scaled = longint'(32'sh7FFF_FFFF);
        if (scaled < -longint'(64'sh8000_0000))
            scaled = -longint'(64'sh8000_0000);
        return OUT_W'(scaled);
    endfunction

    task automatic apply_to_model(input cmd_item_t it);
        conv_result_t res;
        case (it.cmd)
            CMD_WRITE_PIXEL:
                image_mem[int'(it.row) * IMG_DIM + int'(it.col)] = it.pix;
            CMD_WRITE_COEF:
                if (int'(it.cidx) < KTAPS)
                    kernel_coefs[it.cidx] = it.cval;
            CMD_COMPUTE:
            begin
                res.value = convolve_at(int'(it.col), int'(it.row));
                res.col   = it.col;
                res.row   = it.row;
                expected_pixels.push_back(res);
            end
            default:
                ;
        endcase
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // coordinates stay near the image corners or beyond the far edge
    function automatic int pick_coord(input int s);
        int span;
        span = (s > COORD_SPAN) ? COORD_SPAN : s;
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return s - 1;
            2:       return $urandom_range(s - 1, IMG_DIM - 1);
            3, 4:    return $urandom_range(s - span, s - 1);
            default: return $urandom_range(0, span - 1);
        endcase
    endfunction

    function automatic int pick_gap();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 0;
            4, 5, 6:    return $urandom_range(1, 3);
            7, 8:       return $urandom_range(4, 20);
            default:    return $urandom_range(21, 70);
        endcase
    endfunction

    task automatic enqueue(input logic [1:0] cmd, input int col, input int row,
                           input logic signed [PIX_W-1:0] pix, input int cidx,
                           input logic signed [COEF_W-1:0] cval);
        cmd_item_t it;
        it.cmd  = cmd;
        it.col  = COORD_W'(col);
        it.row  = COORD_W'(row);
        it.pix  = pix;
        it.cidx = CIDX_W'(cidx);
        it.cval = cval;
        pending_cmds.push_back(it);
        if (cmd == CMD_WRITE_PIXEL)
            pix_written[row * IMG_DIM + col] = 1'b1;
        else if (cmd == CMD_WRITE_COEF && cidx < KTAPS)
            coef_written[cidx] = 1'b1;
    endtask

    task automatic write_pixel(input int col, input int row, input logic signed [15:0] v);
        enqueue(CMD_WRITE_PIXEL, col, row, v, $urandom_range(0, 63), rand_sample());
    endtask

    task automatic write_coef(input int cidx, input logic signed [15:0] v);
        enqueue(CMD_WRITE_COEF, $urandom_range(0, 255), $urandom_range(0, 255),
                rand_sample(), cidx, v);
    endtask

    // fills any tap of the window that was never written, then asks for the result
    task automatic queue_compute(input int col, input int row);
        int w;
        int h;
        int r;
        int n;
        int ky;
        int kx;
        int sx;
        int sy;
        w = eff_size(cfg_width);
        h = eff_size(cfg_height);
        r = int'(cfg_radius);
        n = 0;
        for (ky = -r; ky <= r; ky++)
        begin
            sy = mirror_tap(row + ky, h);
            for (kx = -r; kx <= r; kx++)
            begin
                sx = mirror_tap(col + kx, w);
                if (!coef_written[n])
                    write_coef(n, rand_sample());
                if (!pix_written[sy * IMG_DIM + sx])
                    write_pixel(sx, sy, rand_sample());
                n++;
            end
        end
        enqueue(CMD_COMPUTE, col, row, rand_sample(), $urandom_range(0, 63), rand_sample());
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int unsigned value);
        logic [CFG_DW-1:0] word;
        word = $urandom();
        if (idx == REG_KERNEL_RADIUS)
            word[RAD_W-1:0] = value[RAD_W-1:0];
        else
            word[SIZE_W-1:0] = value[SIZE_W-1:0];
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:   cfg_width  = word[SIZE_W-1:0];
            REG_IMAGE_HEIGHT:  cfg_height = word[SIZE_W-1:0];
            REG_KERNEL_RADIUS: cfg_radius = word[RAD_W-1:0];
            default:           ;
        endcase
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || start || busy || expected_pixels.size() != 0);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // driver: one command transaction per start/!busy edge, bursts with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_to_model(held_cmd);
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = pick_gap();
                end
            end
            if (!start || !busy)
            begin
                if (gap_left > 0 || pending_cmds.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    start <= 1'b0;
                end
                else
                begin
                    held_cmd    = pending_cmds.pop_front();
                    start       <= 1'b1;
                    command     <= held_cmd.cmd;
                    column      <= held_cmd.col;
                    row_index   <= held_cmd.row;
                    pixel_value <= held_cmd.pix;
                    coef_index  <= held_cmd.cidx;
                    coef_value  <= held_cmd.cval;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        conv_result_t exp_res;
        if (rst_n && out_strobe)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result (%0d,%0d) value %0d",
                                          out_column, out_row, out_value));
            end
            else
            begin
                exp_res = expected_pixels.pop_front();
                if (out_value !== exp_res.value || out_column !== exp_res.col ||
                    out_row !== exp_res.row)
                    report_mismatch($sformatf("exp (%0d,%0d) value %0d, got (%0d,%0d) value %0d",
                                              exp_res.col, exp_res.row, exp_res.value,
                                              out_column, out_row, out_value));
            end
        end
    end

    // watchdog: cycles with no transaction of any kind
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || out_strobe || (psel && penable && pwrite && pready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_kernel_convolution_reflect_border_core: FAIL");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int plan_w [0:NUM_PHASES-1];
        int plan_h [0:NUM_PHASES-1];
        int plan_r [0:NUM_PHASES-1];
        int p;
        int i;
        int sel;
        int w;
        int h;
        plan_w = '{1, 1, 2, 0, 511, 7, 256, 16, 3, 256, 12};
        plan_h = '{1, 1, 3, 0, 300, 5, 256, 4, 256, 1, 9};
        plan_r = '{0, 3, 3, 2, 3, 1, 3, 2, 0, 3, 3};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: ignored writes, reserved command, extreme samples, corners
        write_coef(KTAPS, 16'sh7FFF);
        write_coef(63, 16'sh8000);
        enqueue(CMD_RESERVED, 255, 255, 16'sh7FFF, 63, 16'sh7FFF);
        for (i = 0; i < 9; i++)
            write_coef(i, 16'sh8000);
        write_pixel(0, 0, 16'sh8000);
        write_pixel(1, 0, 16'sh8000);
        write_pixel(0, 1, 16'sh8000);
        write_pixel(1, 1, 16'sh8000);
        queue_compute(0, 0);
        write_pixel(255, 255, 16'sh7FFF);
        queue_compute(255, 255);
        queue_compute(255, 0);
        queue_compute(0, 255);
        write_coef(4, 16'sh7FFF);
        queue_compute(1, 1);
        wait_drained();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_write(REG_IMAGE_WIDTH, plan_w[p]);
            cfg_write(REG_IMAGE_HEIGHT, plan_h[p]);
            cfg_write(REG_KERNEL_RADIUS, plan_r[p]);
            if (p == 4)
                cfg_write(REG_UNMAPPED, $urandom());
            @(negedge clk);
            w = eff_size(cfg_width);
            h = eff_size(cfg_height);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 9)
                    queue_compute(pick_coord(w), pick_coord(h));
                else if (sel < 15)
                    write_pixel(pick_coord(w), pick_coord(h), rand_sample());
                else if (sel < 18)
                    write_coef(($urandom_range(0, 7) == 0) ? $urandom_range(KTAPS, 63)
                                                           : $urandom_range(0, KTAPS - 1),
                               rand_sample());
                else
                    enqueue(CMD_RESERVED, $urandom_range(0, 255), $urandom_range(0, 255),
                            rand_sample(), $urandom_range(0, 63), rand_sample());
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("tb_kernel_convolution_reflect_border_core: PASS");
        else
            $display("tb_kernel_convolution_reflect_border_core: FAIL");
        $finish;
    end

endmodule
